// ----- sv/tccsr_pkg.sv -----
// Constants, types and the color palette table shared by the text cell resolver.
`timescale 1ns / 1ps

package tccsr_pkg;

  localparam int SPRITE_SLOTS     = 1791;
  localparam int SPRITE_BASE_CODE = 57600;
  localparam int CURSOR_ATTR_BIT  = 0;

  localparam int SLOT_W = 11;
  localparam int CODE_W = 21;
  localparam int RGB_W  = 24;
  localparam int ROWS_W = 64;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SPRITE_SLOTS - 1);
  localparam logic [CODE_W-1:0] SPACE_CODE = CODE_W'(32);

  localparam logic [1:0] KIND_GLYPH  = 2'd0;
  localparam logic [1:0] KIND_SPRITE = 2'd1;
  localparam logic [1:0] KIND_REPLY  = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic REQ_RESOLVE  = 1'b0;
  localparam logic REQ_REGISTER = 1'b1;

  typedef logic [255:0][RGB_W-1:0] palette_t;
  typedef logic [5:0][7:0]          cube_lvl_t;
  typedef logic [15:0][RGB_W-1:0]  vga_t;

  localparam cube_lvl_t CUBE_LEVEL = {8'd255, 8'd215, 8'd175, 8'd135, 8'd95, 8'd0};

  localparam vga_t VGA_COLORS = {
    24'hFFFFFF, 24'h00FFFF, 24'hFF00FF, 24'h0000FF,
    24'hFFFF00, 24'h00FF00, 24'hFF0000, 24'h808080,
    24'hC0C0C0, 24'h008080, 24'h800080, 24'h000080,
    24'h808000, 24'h008000, 24'h800000, 24'h000000
  };

  function automatic palette_t build_palette();
    palette_t  tbl;
    int        idx;
    logic [7:0] v;
    tbl = '0;
    for (int i = 0; i < 16; i++) begin
      tbl[i] = VGA_COLORS[i];
    end
    idx = 16;
    for (int r = 0; r < 6; r++) begin
      for (int g = 0; g < 6; g++) begin
        for (int b = 0; b < 6; b++) begin
          tbl[idx] = {CUBE_LEVEL[r], CUBE_LEVEL[g], CUBE_LEVEL[b]};
          idx++;
        end
      end
    end
    for (int i = 0; i < 24; i++) begin
      v = 8'(8 + 10 * i);
      tbl[232 + i] = {v, v, v};
    end
    return tbl;
  endfunction

  localparam palette_t PALETTE = build_palette();

endpackage

// ----- sv/text_cell_color_sprite_resolver.sv -----
// Top level of the text cell resolver: sprite store, palette lookup and result register.
`timescale 1ns / 1ps

// Text cell resolver.
// Input channel: an item is taken at a rising edge with start high and busy low.
// A register item (in_req_type 1) writes a 16-row sprite bitmap into a slot and
// answers with a reply; status flags a slot beyond the store. A resolve item maps
// the fg/bg palette indices to RGB, applies the cursor swap and space substitution,
// and returns a sprite draw when its codepoint names a valid sprite slot, else a
// glyph draw at pixel (col*8, row*16).
// Result channel: each result shows for one cycle with out_strobe high; the
// receiver cannot stall it.
// Path: each item is registered in the input stage, then in the result register.
// Throughput: one item per cycle while busy is low; the sprite store is read and
// written at the accepting edge through one write port and one read port.
// Reset: after rst_n is released, the valid map is cleared one slot per cycle
// while busy is high. The bitmap store is not cleared.
module text_cell_color_sprite_resolver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic [7:0]                        in_cell_col,
  input  logic [7:0]                        in_cell_row,
  input  logic [tccsr_pkg::CODE_W-1:0]      in_code_point,
  input  logic [7:0]                        in_fg_index,
  input  logic [7:0]                        in_bg_index,
  input  logic [15:0]                       in_cell_attrs,
  input  logic [tccsr_pkg::SLOT_W-1:0]      in_sprite_slot,
  input  logic [tccsr_pkg::ROWS_W-1:0]      in_bitmap_low,
  input  logic [tccsr_pkg::ROWS_W-1:0]      in_bitmap_high,
  output logic                              out_strobe,
  output logic                              out_status,
  output logic [1:0]                        out_draw_kind,
  output logic [10:0]                       out_pixel_x,
  output logic [11:0]                       out_pixel_y,
  output logic [tccsr_pkg::CODE_W-1:0]      out_glyph_code,
  output logic [tccsr_pkg::RGB_W-1:0]       out_fg_rgb,
  output logic [tccsr_pkg::RGB_W-1:0]       out_bg_rgb,
  output logic [tccsr_pkg::ROWS_W-1:0]      out_sprite_rows_low,
  output logic [tccsr_pkg::ROWS_W-1:0]      out_sprite_rows_high
);

  localparam int SW = tccsr_pkg::SLOT_W;
  localparam int CW = tccsr_pkg::CODE_W;
  localparam int RW = tccsr_pkg::ROWS_W;
  localparam int PW = tccsr_pkg::RGB_W;

  localparam logic [CW-1:0] BASE_CODE  = CW'(tccsr_pkg::SPRITE_BASE_CODE);
  localparam logic [CW-1:0] SLOTS_CODE = CW'(tccsr_pkg::SPRITE_SLOTS);
  localparam logic [SW-1:0] SLOTS_SLOT = SW'(tccsr_pkg::SPRITE_SLOTS);

  logic          valid_mem [tccsr_pkg::SPRITE_SLOTS];
  logic [RW-1:0] low_mem   [tccsr_pkg::SPRITE_SLOTS];
  logic [RW-1:0] high_mem  [tccsr_pkg::SPRITE_SLOTS];

  logic          clearing_r;
  logic [SW-1:0] clr_cnt_r;

  logic          accept;
  logic [CW-1:0] code_off;
  logic          code_in_range;
  logic [SW-1:0] rd_addr;
  logic          slot_ok;
  logic          wr_item;
  logic          valid_we;
  logic [SW-1:0] valid_wa;
  logic          valid_wd;

  logic          s1_valid_r;
  logic          s1_req_r;
  logic [7:0]    s1_col_r;
  logic [7:0]    s1_row_r;
  logic [CW-1:0] s1_code_r;
  logic [7:0]    s1_fg_idx_r;
  logic [7:0]    s1_bg_idx_r;
  logic          s1_cursor_r;
  logic          s1_slot_ok_r;
  logic          s1_in_range_r;
  logic          s1_valid_rd_r;
  logic [RW-1:0] s1_low_rd_r;
  logic [RW-1:0] s1_high_rd_r;

  logic          strobe_r;
  logic          status_r,  status_nxt;
  logic [1:0]    kind_r,    kind_nxt;
  logic [10:0]   px_r,      px_nxt;
  logic [11:0]   py_r,      py_nxt;
  logic [CW-1:0] glyph_r,   glyph_nxt;
  logic [PW-1:0] fg_r,      fg_nxt;
  logic [PW-1:0] bg_r,      bg_nxt;
  logic [RW-1:0] rows_lo_r, rows_lo_nxt;
  logic [RW-1:0] rows_hi_r, rows_hi_nxt;

  logic [PW-1:0] fg_pal;
  logic [PW-1:0] bg_pal;
  logic          sprite_hit;

  assign busy   = clearing_r;
  assign accept = start && !clearing_r;

  assign code_off      = in_code_point - BASE_CODE;
  assign code_in_range = (in_code_point >= BASE_CODE) && (code_off < SLOTS_CODE);
  assign rd_addr       = code_in_range ? code_off[SW-1:0] : '0;
  assign slot_ok       = in_sprite_slot < SLOTS_SLOT;
  assign wr_item       = accept && (in_req_type == tccsr_pkg::REQ_REGISTER) && slot_ok;

  assign valid_we = clearing_r || wr_item;
  assign valid_wa = clearing_r ? clr_cnt_r : in_sprite_slot;
  assign valid_wd = !clearing_r;

  // Valid map clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == tccsr_pkg::SLOT_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid_we) begin
      valid_mem[valid_wa] <= valid_wd;
    end
    s1_valid_rd_r <= valid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_item) begin
      low_mem[in_sprite_slot]  <= in_bitmap_low;
      high_mem[in_sprite_slot] <= in_bitmap_high;
    end
    s1_low_rd_r  <= low_mem[rd_addr];
    s1_high_rd_r <= high_mem[rd_addr];
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r      <= in_req_type;
    s1_col_r      <= in_cell_col;
    s1_row_r      <= in_cell_row;
    s1_code_r     <= in_code_point;
    s1_fg_idx_r   <= in_fg_index;
    s1_bg_idx_r   <= in_bg_index;
    s1_cursor_r   <= in_cell_attrs[tccsr_pkg::CURSOR_ATTR_BIT];
    s1_slot_ok_r  <= slot_ok;
    s1_in_range_r <= code_in_range;
  end

  assign fg_pal     = tccsr_pkg::PALETTE[s1_fg_idx_r];
  assign bg_pal     = tccsr_pkg::PALETTE[s1_bg_idx_r];
  assign sprite_hit = s1_in_range_r && s1_valid_rd_r;

  always_comb begin
    status_nxt  = tccsr_pkg::STATUS_OK;
    kind_nxt    = tccsr_pkg::KIND_GLYPH;
    px_nxt      = '0;
    py_nxt      = '0;
    glyph_nxt   = '0;
    fg_nxt      = '0;
    bg_nxt      = '0;
    rows_lo_nxt = '0;
    rows_hi_nxt = '0;
    case (s1_req_r)
      tccsr_pkg::REQ_REGISTER: begin
        kind_nxt   = tccsr_pkg::KIND_REPLY;
        status_nxt = s1_slot_ok_r ? tccsr_pkg::STATUS_OK : tccsr_pkg::STATUS_RANGE;
      end
      default: begin
        px_nxt    = {s1_col_r, 3'b000};
        py_nxt    = {s1_row_r, 4'b0000};
        glyph_nxt = s1_code_r;
        fg_nxt    = fg_pal;
        bg_nxt    = bg_pal;
        if (s1_cursor_r) begin
          fg_nxt = bg_pal;
          bg_nxt = fg_pal;
          if (s1_code_r == '0) begin
            glyph_nxt = tccsr_pkg::SPACE_CODE;
          end
        end
        if (sprite_hit) begin
          kind_nxt    = tccsr_pkg::KIND_SPRITE;
          rows_lo_nxt = s1_low_rd_r;
          rows_hi_nxt = s1_high_rd_r;
        end
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    kind_r    <= kind_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    glyph_r   <= glyph_nxt;
    fg_r      <= fg_nxt;
    bg_r      <= bg_nxt;
    rows_lo_r <= rows_lo_nxt;
    rows_hi_r <= rows_hi_nxt;
  end

  assign out_strobe           = strobe_r;
  assign out_status           = status_r;
  assign out_draw_kind        = kind_r;
  assign out_pixel_x          = px_r;
  assign out_pixel_y          = py_r;
  assign out_glyph_code       = glyph_r;
  assign out_fg_rgb           = fg_r;
  assign out_bg_rgb           = bg_r;
  assign out_sprite_rows_low  = rows_lo_r;
  assign out_sprite_rows_high = rows_hi_r;

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_valid_r)
    else $error("item in flight during valid map clear");

  a_register_gives_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == tccsr_pkg::REQ_REGISTER)
    |=> ##1 (out_strobe && out_draw_kind == tccsr_pkg::KIND_REPLY))
    else $error("register item did not give a reply");

  a_resolve_gives_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == tccsr_pkg::REQ_RESOLVE)
    |=> ##1 (out_strobe && out_draw_kind != tccsr_pkg::KIND_REPLY
             && out_status == tccsr_pkg::STATUS_OK))
    else $error("resolve item did not give a draw");

  a_sprite_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_draw_kind == tccsr_pkg::KIND_SPRITE)
    |-> (out_glyph_code >= BASE_CODE))
    else $error("sprite draw for a code below the sprite base");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the text cell resolver: palette, cursor, sprite store and random traffic checks.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                              req_type;
    logic [7:0]                        col;
    logic [7:0]                        row;
    logic [tccsr_pkg::CODE_W-1:0]      code_point;
    logic [7:0]                        fg_index;
    logic [7:0]                        bg_index;
    logic [15:0]                       attrs;
    logic [tccsr_pkg::SLOT_W-1:0]      slot;
    logic [tccsr_pkg::ROWS_W-1:0]      bitmap_low;
    logic [tccsr_pkg::ROWS_W-1:0]      bitmap_high;
  } cell_item_t;

  typedef struct packed {
    logic                              status;
    logic [1:0]                        draw_kind;
    logic [10:0]                       pixel_x;
    logic [11:0]                       pixel_y;
    logic [tccsr_pkg::CODE_W-1:0]      glyph_code;
    logic [tccsr_pkg::RGB_W-1:0]       fg_rgb;
    logic [tccsr_pkg::RGB_W-1:0]       bg_rgb;
    logic [tccsr_pkg::ROWS_W-1:0]      rows_low;
    logic [tccsr_pkg::ROWS_W-1:0]      rows_high;
  } draw_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_req_type = 1'b0;
  logic [7:0]                        in_cell_col = '0;
  logic [7:0]                        in_cell_row = '0;
  logic [tccsr_pkg::CODE_W-1:0]      in_code_point = '0;
  logic [7:0]                        in_fg_index = '0;
  logic [7:0]                        in_bg_index = '0;
  logic [15:0]                       in_cell_attrs = '0;
  logic [tccsr_pkg::SLOT_W-1:0]      in_sprite_slot = '0;
  logic [tccsr_pkg::ROWS_W-1:0]      in_bitmap_low = '0;
  logic [tccsr_pkg::ROWS_W-1:0]      in_bitmap_high = '0;
  logic                              out_strobe;
  logic                              out_status;
  logic [1:0]                        out_draw_kind;
  logic [10:0]                       out_pixel_x;
  logic [11:0]                       out_pixel_y;
  logic [tccsr_pkg::CODE_W-1:0]      out_glyph_code;
  logic [tccsr_pkg::RGB_W-1:0]       out_fg_rgb;
  logic [tccsr_pkg::RGB_W-1:0]       out_bg_rgb;
  logic [tccsr_pkg::ROWS_W-1:0]      out_sprite_rows_low;
  logic [tccsr_pkg::ROWS_W-1:0]      out_sprite_rows_high;

  text_cell_color_sprite_resolver dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_cell_col          (in_cell_col),
    .in_cell_row          (in_cell_row),
    .in_code_point        (in_code_point),
    .in_fg_index          (in_fg_index),
    .in_bg_index          (in_bg_index),
    .in_cell_attrs        (in_cell_attrs),
    .in_sprite_slot       (in_sprite_slot),
    .in_bitmap_low        (in_bitmap_low),
    .in_bitmap_high       (in_bitmap_high),
    .out_strobe           (out_strobe),
    .out_status           (out_status),
    .out_draw_kind        (out_draw_kind),
    .out_pixel_x          (out_pixel_x),
    .out_pixel_y          (out_pixel_y),
    .out_glyph_code       (out_glyph_code),
    .out_fg_rgb           (out_fg_rgb),
    .out_bg_rgb           (out_bg_rgb),
    .out_sprite_rows_low  (out_sprite_rows_low),
    .out_sprite_rows_high (out_sprite_rows_high)
  );

  bit                           slot_valid [tccsr_pkg::SPRITE_SLOTS];
  logic [tccsr_pkg::ROWS_W-1:0] slot_rows_low [tccsr_pkg::SPRITE_SLOTS];
  logic [tccsr_pkg::ROWS_W-1:0] slot_rows_high [tccsr_pkg::SPRITE_SLOTS];
  draw_result_t    pending_draws[$];
  draw_result_t    oldest_draw;
  int              mismatch_count = 0;
  int              cycle_count = 0;
  bit              gaps_on = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [7:0] cube_level(int n);
    return (n == 0) ? 8'd0 : 8'(55 + 40 * n);
  endfunction

  function automatic logic [tccsr_pkg::RGB_W-1:0] xterm_rgb(logic [7:0] idx);
    int         k;
    logic [7:0] v;
    if (idx < 16) begin
      case (idx[3:0])
        4'd0:  return 24'h000000;
        4'd1:  return 24'h800000;
        4'd2:  return 24'h008000;
        4'd3:  return 24'h808000;
        4'd4:  return 24'h000080;
        4'd5:  return 24'h800080;
        4'd6:  return 24'h008080;
        4'd7:  return 24'hC0C0C0;
        4'd8:  return 24'h808080;
        4'd9:  return 24'hFF0000;
        4'd10: return 24'h00FF00;
        4'd11: return 24'hFFFF00;
        4'd12: return 24'h0000FF;
        4'd13: return 24'hFF00FF;
        4'd14: return 24'h00FFFF;
        default: return 24'hFFFFFF;
      endcase
    end
    if (idx < 232) begin
      k = int'(idx) - 16;
      return {cube_level(k / 36), cube_level((k / 6) % 6), cube_level(k % 6)};
    end
    v = 8'(8 + 10 * (int'(idx) - 232));
    return {v, v, v};
  endfunction

  function automatic draw_result_t resolve_draw(cell_item_t it);
    draw_result_t                 r;
    logic [tccsr_pkg::RGB_W-1:0]  fg_c;
    logic [tccsr_pkg::RGB_W-1:0]  bg_c;
    logic [tccsr_pkg::CODE_W-1:0] cp;
    int                           sid;
    r = '0;
    if (it.req_type == tccsr_pkg::REQ_REGISTER) begin
      r.draw_kind = tccsr_pkg::KIND_REPLY;
      if (int'(it.slot) >= tccsr_pkg::SPRITE_SLOTS) begin
        r.status = tccsr_pkg::STATUS_RANGE;
      end else begin
        r.status = tccsr_pkg::STATUS_OK;
        slot_rows_low[it.slot]  = it.bitmap_low;
        slot_rows_high[it.slot] = it.bitmap_high;
        slot_valid[it.slot]     = 1'b1;
      end
      return r;
    end
    fg_c = xterm_rgb(it.fg_index);
    bg_c = xterm_rgb(it.bg_index);
    cp   = it.code_point;
    if (it.attrs[tccsr_pkg::CURSOR_ATTR_BIT]) begin
      {fg_c, bg_c} = {bg_c, fg_c};
      if (cp == '0) cp = tccsr_pkg::SPACE_CODE;
    end
    r.status     = tccsr_pkg::STATUS_OK;
    r.draw_kind  = tccsr_pkg::KIND_GLYPH;
    r.pixel_x    = {it.col, 3'b000};
    r.pixel_y    = {it.row, 4'b0000};
    r.glyph_code = cp;
    r.fg_rgb     = fg_c;
    r.bg_rgb     = bg_c;
    sid = int'(cp) - tccsr_pkg::SPRITE_BASE_CODE;
    if (sid >= 0 && sid < tccsr_pkg::SPRITE_SLOTS && slot_valid[sid]) begin
      r.draw_kind = tccsr_pkg::KIND_SPRITE;
      r.rows_low  = slot_rows_low[sid];
      r.rows_high = slot_rows_high[sid];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
    mismatch_count++;
    $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want_v, got_v);
  endtask

  task automatic check_field(string what, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) report_mismatch(what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_draws.size() == 0) begin
        report_mismatch("unexpected result", '0, 64'(out_draw_kind));
      end else begin
        oldest_draw = pending_draws.pop_front();
        check_field("status", 64'(oldest_draw.status), 64'(out_status));
        check_field("draw_kind", 64'(oldest_draw.draw_kind), 64'(out_draw_kind));
        check_field("pixel_x", 64'(oldest_draw.pixel_x), 64'(out_pixel_x));
        check_field("pixel_y", 64'(oldest_draw.pixel_y), 64'(out_pixel_y));
        check_field("glyph_code", 64'(oldest_draw.glyph_code), 64'(out_glyph_code));
        check_field("fg_rgb", 64'(oldest_draw.fg_rgb), 64'(out_fg_rgb));
        check_field("bg_rgb", 64'(oldest_draw.bg_rgb), 64'(out_bg_rgb));
        check_field("sprite_rows_low", oldest_draw.rows_low, out_sprite_rows_low);
        check_field("sprite_rows_high", oldest_draw.rows_high, out_sprite_rows_high);
      end
    end
  end

  // after an optional random gap, hold the item until busy is low at an edge, then record its draw
  task automatic send_item(cell_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start          <= 1'b1;
    in_req_type    <= it.req_type;
    in_cell_col    <= it.col;
    in_cell_row    <= it.row;
    in_code_point  <= it.code_point;
    in_fg_index    <= it.fg_index;
    in_bg_index    <= it.bg_index;
    in_cell_attrs  <= it.attrs;
    in_sprite_slot <= it.slot;
    in_bitmap_low  <= it.bitmap_low;
    in_bitmap_high <= it.bitmap_high;
    do @(posedge clk); while (busy !== 1'b0);
    pending_draws.push_back(resolve_draw(it));
  endtask

  function automatic logic [tccsr_pkg::SLOT_W-1:0] pick_slot();
    case ($urandom_range(0, 3))
      0: return tccsr_pkg::SLOT_W'($urandom_range(0, 15));
      1: return tccsr_pkg::SLOT_W'($urandom_range(tccsr_pkg::SPRITE_SLOTS - 16,
                                                   tccsr_pkg::SPRITE_SLOTS - 1));
      2: return tccsr_pkg::SLOT_W'($urandom_range(0, tccsr_pkg::SPRITE_SLOTS - 1));
      default: return tccsr_pkg::SLOT_W'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic cell_item_t random_item();
    cell_item_t it;
    it.req_type    = ($urandom_range(0, 9) < 3) ? tccsr_pkg::REQ_REGISTER
                                                : tccsr_pkg::REQ_RESOLVE;
    it.col         = 8'($urandom);
    it.row         = 8'($urandom);
    it.fg_index    = 8'($urandom);
    it.bg_index    = 8'($urandom);
    it.attrs       = 16'($urandom);
    it.slot        = pick_slot();
    it.bitmap_low  = {$urandom, $urandom};
    it.bitmap_high = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: it.code_point = tccsr_pkg::CODE_W'(tccsr_pkg::SPRITE_BASE_CODE
                                                        + int'(pick_slot()));
      5: it.code_point = '0;
      6: it.code_point = tccsr_pkg::CODE_W'($urandom_range(0, 32'h10FFFF));
      default: it.code_point = tccsr_pkg::CODE_W'($urandom);
    endcase
    return it;
  endfunction

  function automatic cell_item_t resolve_item(logic [7:0] col, logic [7:0] row,
                                              logic [tccsr_pkg::CODE_W-1:0] cp,
                                              logic [7:0] fg,
                                              logic [7:0] bg, logic [15:0] attrs);
    cell_item_t it;
    it            = random_item();
    it.req_type   = tccsr_pkg::REQ_RESOLVE;
    it.col        = col;
    it.row        = row;
    it.code_point = cp;
    it.fg_index   = fg;
    it.bg_index   = bg;
    it.attrs      = attrs;
    return it;
  endfunction

  function automatic cell_item_t register_item(int slot, logic [tccsr_pkg::ROWS_W-1:0] lo,
                                               logic [tccsr_pkg::ROWS_W-1:0] hi);
    cell_item_t it;
    it             = random_item();
    it.req_type    = tccsr_pkg::REQ_REGISTER;
    it.slot        = tccsr_pkg::SLOT_W'(slot);
    it.bitmap_low  = lo;
    it.bitmap_high = hi;
    return it;
  endfunction

  task automatic test_palette_edges();
    send_item(resolve_item(8'd0, 8'd0, 21'h41, 8'd0, 8'd255, 16'h0000));
    send_item(resolve_item(8'd255, 8'd255, 21'h42, 8'd255, 8'd0, 16'hFFFE));
    send_item(resolve_item(8'd1, 8'd2, 21'h43, 8'd15, 8'd16, 16'h0000));
    send_item(resolve_item(8'd128, 8'd127, 21'h44, 8'd231, 8'd232, 16'h0000));
    send_item(resolve_item(8'd7, 8'd9, 21'h45, 8'd7, 8'd196, 16'h0000));
  endtask

  task automatic test_cursor();
    send_item(resolve_item(8'd3, 8'd4, 21'h0, 8'd1, 8'd2, 16'h0000));
    send_item(resolve_item(8'd3, 8'd4, 21'h0, 8'd1, 8'd2, 16'h0001));
    send_item(resolve_item(8'd255, 8'd0, 21'h1FFFFF, 8'd9, 8'd250, 16'hFFFF));
  endtask

  task automatic test_sprite_store();
    send_item(resolve_item(8'd5, 8'd5, tccsr_pkg::CODE_W'(tccsr_pkg::SPRITE_BASE_CODE + 1),
                           8'd2, 8'd3, 16'h0));
    send_item(register_item(0, '0, '0));
    send_item(register_item(tccsr_pkg::SPRITE_SLOTS - 1, '1, '1));
    send_item(register_item(tccsr_pkg::SPRITE_SLOTS, {$urandom, $urandom},
                            {$urandom, $urandom}));
    send_item(register_item(2047, '1, '1));
    send_item(resolve_item(8'd10, 8'd20, tccsr_pkg::CODE_W'(tccsr_pkg::SPRITE_BASE_CODE),
                           8'd4, 8'd5, 16'h0));
    send_item(resolve_item(8'd11, 8'd21,
                           tccsr_pkg::CODE_W'(tccsr_pkg::SPRITE_BASE_CODE
                                              + tccsr_pkg::SPRITE_SLOTS - 1),
                           8'd100, 8'd200, 16'h0));
    send_item(resolve_item(8'd12, 8'd22,
                           tccsr_pkg::CODE_W'(tccsr_pkg::SPRITE_BASE_CODE
                                              + tccsr_pkg::SPRITE_SLOTS),
                           8'd6, 8'd7, 16'h0));
    send_item(resolve_item(8'd13, 8'd23,
                           tccsr_pkg::CODE_W'(tccsr_pkg::SPRITE_BASE_CODE - 1),
                           8'd8, 8'd9, 16'h0));
    send_item(register_item(0, {$urandom, $urandom}, {$urandom, $urandom}));
    send_item(resolve_item(8'd14, 8'd24, tccsr_pkg::CODE_W'(tccsr_pkg::SPRITE_BASE_CODE),
                           8'd30, 8'd240, 16'h0001));
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      send_item(random_item());
    end
  endtask

  task automatic test_back_to_back(int count);
    gaps_on = 1'b0;
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_palette_edges();
    test_cursor();
    test_sprite_store();
    test_random_traffic(830);
    test_back_to_back(150);
    start <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tccsr_pkg.sv
sv/text_cell_color_sprite_resolver.sv
tb/tb.sv
